FILE: hw/rtl/idla_pkg.sv
// Package with the types and constants shared by the aggregation block files.
package idla_pkg;

   localparam int OPCODE_BITS     = 1;
   localparam int RANDOM_BITS     = 16;
   localparam int SITE_COORD_BITS = 14;
   localparam int SITE_NUM_BITS   = 12;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 6;
   localparam int RADIUS_BITS     = 3;
   localparam int PARTICLE_BITS   = 6;
   localparam int SOURCE_BITS     = 8;
   localparam int SIDE_BITS       = 4;
   localparam int DIV_STEPS_BITS  = 3;

   localparam logic [OPCODE_BITS-1:0] OP_STEP    = 1'b0;
   localparam logic [OPCODE_BITS-1:0] OP_RESTART = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SOURCE_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARTICLES     = 2'd1;

   localparam logic [RADIUS_BITS-1:0]   RADIUS_RESET    = 3'd1;
   localparam logic [PARTICLE_BITS-1:0] PARTICLES_RESET = 6'd1;

   typedef logic signed [SITE_COORD_BITS-1:0] coord_out_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SETTLE,
      ST_DIV
   } state_type;

   typedef enum logic [2:0] {
      DIR_XP,
      DIR_XN,
      DIR_YP,
      DIR_YN,
      DIR_ZP,
      DIR_ZN
   } dir_type;

endpackage

FILE: hw/rtl/idla_if.sv
// Handshake interfaces for the request and response channels of the aggregation block.
interface idla_req_if;
   logic                                valid;
   logic                                ready;
   logic [idla_pkg::OPCODE_BITS-1:0]    opcode;
   logic [idla_pkg::RANDOM_BITS-1:0]    random_value;

   modport source (output valid, output opcode, output random_value, input ready);
   modport sink   (input valid, input opcode, input random_value, output ready);
endinterface

interface idla_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [idla_pkg::SITE_COORD_BITS-1:0] site_x;
   logic signed [idla_pkg::SITE_COORD_BITS-1:0] site_y;
   logic signed [idla_pkg::SITE_COORD_BITS-1:0] site_z;
   logic [idla_pkg::SITE_NUM_BITS-1:0]      site_number;
   logic                                    run_last;
   logic                                    store_full;

   modport source (output valid, output site_x, output site_y, output site_z,
                   output site_number, output run_last, output store_full, input ready);
   modport sink   (input valid, input site_x, input site_y, input site_z,
                   input site_number, input run_last, input store_full, output ready);
endinterface

FILE: hw/rtl/idla_ram.sv
// Generic single write port, single read port RAM with registered read data.
module idla_ram #(
   parameter int WIDTH = 42,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/idla_multi_source_3d.sv
// Top level of the three-dimensional multi-source internal aggregation block.
//
//   channel  | direction | contents
//   ---------+-----------+-----------------------------------------------------
//   req_chan | in        | opcode, random_value (step or restart)
//   rsp_chan | out       | site_x, site_y, site_z, site_number, run_last, store_full
//   csr_*    | in        | write enable, register index, write data
//
// A restart, or a step after the run has ended, is completed without leaving the idle state.
// A step that moves the walker scans the site store one entry a cycle through its single
// read port, stopping at the first match.
// A step that settles a particle scans the whole store, or none of it on an empty store;
// unless the run ends, a bit-serial divider then places the next walker at its source.
// Reset is synchronous; the site store needs no clearing pass since only entries
// below the fill count are ever read.
// A settled particle waits in the store write cycle while the response register is full.
module idla_multi_source_3d #(
   parameter int MAX_SITES  = 4096,
   parameter int COORD_BITS = 14
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [idla_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [idla_pkg::CSR_DATA_BITS-1:0]   csr_data,
   idla_req_if.sink                             req_chan,
   idla_rsp_if.source                           rsp_chan
);

   localparam int AW = $clog2(MAX_SITES);
   localparam int CW = $clog2(MAX_SITES + 1);
   localparam int WW = 3 * COORD_BITS;
   localparam int RANDOM_PROD_BITS = idla_pkg::RANDOM_BITS + 3;

   idla_pkg::state_type                     state_ff, state_in;
   logic [idla_pkg::RADIUS_BITS-1:0]        radius_ff, radius_in;
   logic [idla_pkg::PARTICLE_BITS-1:0]      pps_ff, pps_in;
   logic [CW-1:0]                           count_ff, count_in;
   logic [COORD_BITS-1:0]                   walk_x_ff, walk_x_in;
   logic [COORD_BITS-1:0]                   walk_y_ff, walk_y_in;
   logic [COORD_BITS-1:0]                   walk_z_ff, walk_z_in;
   logic [idla_pkg::SOURCE_BITS-1:0]        source_ff, source_in;
   logic [idla_pkg::PARTICLE_BITS-1:0]      released_ff, released_in;
   logic                                    done_ff, done_in;
   logic [CW-1:0]                           scan_addr_ff, scan_addr_in;
   logic                                    cmp_vld_ff, cmp_vld_in;
   logic                                    cmp_last_ff, cmp_last_in;
   idla_pkg::dir_type                       dir_ff, dir_in;
   logic [idla_pkg::DIV_STEPS_BITS-1:0]     div_cnt_ff, div_cnt_in;
   logic [idla_pkg::SOURCE_BITS-1:0]        div_q_ff, div_q_in;
   logic [idla_pkg::SIDE_BITS-1:0]          div_rem_ff, div_rem_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   idla_pkg::coord_out_type                 rsp_x_ff, rsp_x_in;
   idla_pkg::coord_out_type                 rsp_y_ff, rsp_y_in;
   idla_pkg::coord_out_type                 rsp_z_ff, rsp_z_in;
   logic [idla_pkg::SITE_NUM_BITS-1:0]      rsp_num_ff, rsp_num_in;
   logic                                    rsp_last_ff, rsp_last_in;
   logic                                    rsp_full_ff, rsp_full_in;

   logic [idla_pkg::SIDE_BITS-1:0]          side;
   logic [idla_pkg::SOURCE_BITS-1:0]        sources;
   logic [CW-1:0]                           count_inc;
   logic [idla_pkg::PARTICLE_BITS-1:0]      rel_inc;
   logic [idla_pkg::SOURCE_BITS-1:0]        src_inc;
   logic                                    rel_wrap;
   logic                                    src_end;
   logic                                    store_fills;
   logic [RANDOM_PROD_BITS-1:0]             rand_prod;
   logic [WW-1:0]                           walker_word;
   logic [WW-1:0]                           rd_data;
   logic                                    hit;
   logic                                    issue;
   logic                                    out_free;
   logic                                    req_accept;
   logic                                    mem_wr;
   logic [idla_pkg::SIDE_BITS:0]            div_trial;
   logic                                    div_ge;
   logic [idla_pkg::RADIUS_BITS-1:0]        csr_radius;
   logic                                    csr_known;
   logic signed [COORD_BITS-1:0]            wx_s, wy_s, wz_s;

   assign side        = {radius_ff, 1'b1};
   assign sources     = {4'b0000, side} * {4'b0000, side};
   assign count_inc   = count_ff + CW'(1);
   assign rel_inc     = released_ff + 6'd1;
   assign src_inc     = source_ff + 8'd1;
   assign rel_wrap    = (rel_inc >= pps_ff) || (rel_inc == '0);
   assign src_end     = (src_inc >= sources) || (src_inc == '0);
   assign store_fills = (count_inc == CW'(MAX_SITES));
   assign rand_prod   = {1'b0, req_chan.random_value, 2'b00}
                      + {2'b00, req_chan.random_value, 1'b0};
   assign walker_word = {walk_x_ff, walk_y_ff, walk_z_ff};
   assign hit         = cmp_vld_ff && (rd_data == walker_word);
   assign issue       = (state_ff == idla_pkg::ST_SCAN) && (scan_addr_ff < count_ff);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept  = req_chan.valid && (state_ff == idla_pkg::ST_IDLE);
   assign div_trial   = {div_rem_ff, div_q_ff[idla_pkg::SOURCE_BITS-1]};
   assign div_ge      = (div_trial >= {1'b0, side});
   assign wx_s        = walk_x_ff;
   assign wy_s        = walk_y_ff;
   assign wz_s        = walk_z_ff;

   idla_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_SITES)
   ) u_site_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (walker_word),
      .rd_en   (issue),
      .rd_addr (scan_addr_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      radius_in    = radius_ff;
      pps_in       = pps_ff;
      count_in     = count_ff;
      walk_x_in    = walk_x_ff;
      walk_y_in    = walk_y_ff;
      walk_z_in    = walk_z_ff;
      source_in    = source_ff;
      released_in  = released_ff;
      done_in      = done_ff;
      scan_addr_in = scan_addr_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_last_in  = cmp_last_ff;
      dir_in       = dir_ff;
      div_cnt_in   = div_cnt_ff;
      div_q_in     = div_q_ff;
      div_rem_in   = div_rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rsp_num_in   = rsp_num_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_full_in  = rsp_full_ff;
      mem_wr       = 1'b0;
      csr_radius   = radius_ff;
      csr_known    = 1'b0;

      unique case (state_ff)
         idla_pkg::ST_IDLE: begin
            if (req_accept) begin
               if (req_chan.opcode == idla_pkg::OP_RESTART) begin
                  count_in    = '0;
                  source_in   = '0;
                  released_in = '0;
                  done_in     = 1'b0;
                  walk_x_in   = '0;
                  walk_y_in   = COORD_BITS'(0) - COORD_BITS'(radius_ff);
                  walk_z_in   = COORD_BITS'(0) - COORD_BITS'(radius_ff);
               end else if (!done_ff) begin
                  dir_in       = idla_pkg::dir_type'(rand_prod[RANDOM_PROD_BITS-1 -: 3]);
                  scan_addr_in = '0;
                  cmp_vld_in   = 1'b0;
                  cmp_last_in  = 1'b0;
                  if (count_ff == '0) begin
                     state_in = idla_pkg::ST_SETTLE;
                  end else begin
                     state_in = idla_pkg::ST_SCAN;
                  end
               end
            end
         end
         idla_pkg::ST_SCAN: begin
            if (issue) begin
               scan_addr_in = scan_addr_ff + CW'(1);
            end
            cmp_vld_in  = issue;
            cmp_last_in = (scan_addr_ff + CW'(1) == count_ff);
            if (hit) begin
               cmp_vld_in = 1'b0;
               state_in   = idla_pkg::ST_IDLE;
               case (dir_ff)
                  idla_pkg::DIR_XP: walk_x_in = walk_x_ff + COORD_BITS'(1);
                  idla_pkg::DIR_XN: walk_x_in = walk_x_ff - COORD_BITS'(1);
                  idla_pkg::DIR_YP: walk_y_in = walk_y_ff + COORD_BITS'(1);
                  idla_pkg::DIR_YN: walk_y_in = walk_y_ff - COORD_BITS'(1);
                  idla_pkg::DIR_ZP: walk_z_in = walk_z_ff + COORD_BITS'(1);
                  idla_pkg::DIR_ZN: walk_z_in = walk_z_ff - COORD_BITS'(1);
                  default: walk_x_in = walk_x_ff;
               endcase
            end else if (cmp_vld_ff && cmp_last_ff) begin
               cmp_vld_in = 1'b0;
               state_in   = idla_pkg::ST_SETTLE;
            end
         end
         idla_pkg::ST_SETTLE: begin
            if (out_free) begin
               mem_wr       = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_x_in     = idla_pkg::coord_out_type'(wx_s);
               rsp_y_in     = idla_pkg::coord_out_type'(wy_s);
               rsp_z_in     = idla_pkg::coord_out_type'(wz_s);
               rsp_num_in   = idla_pkg::SITE_NUM_BITS'(count_ff);
               rsp_full_in  = store_fills;
               rsp_last_in  = store_fills || (rel_wrap && src_end);
               count_in     = count_inc;
               released_in  = rel_wrap ? '0 : rel_inc;
               source_in    = rel_wrap ? src_inc : source_ff;
               if (store_fills || (rel_wrap && src_end)) begin
                  done_in  = 1'b1;
                  state_in = idla_pkg::ST_IDLE;
               end else begin
                  div_cnt_in = '0;
                  div_q_in   = rel_wrap ? src_inc : source_ff;
                  div_rem_in = '0;
                  state_in   = idla_pkg::ST_DIV;
               end
            end
         end
         idla_pkg::ST_DIV: begin
            div_cnt_in = div_cnt_ff + 3'd1;
            div_q_in   = {div_q_ff[idla_pkg::SOURCE_BITS-2:0], div_ge};
            div_rem_in = div_ge ? idla_pkg::SIDE_BITS'(div_trial - {1'b0, side})
                                : idla_pkg::SIDE_BITS'(div_trial);
            if (div_cnt_ff == '1) begin
               walk_x_in = '0;
               walk_y_in = COORD_BITS'(div_q_in) - COORD_BITS'(radius_ff);
               walk_z_in = COORD_BITS'(div_rem_in) - COORD_BITS'(radius_ff);
               state_in  = idla_pkg::ST_IDLE;
            end
         end
         default: state_in = idla_pkg::ST_IDLE;
      endcase

      if (csr_write_en) begin
         unique case (csr_index)
            idla_pkg::CSR_SOURCE_RADIUS: begin
               radius_in  = csr_data[idla_pkg::RADIUS_BITS-1:0];
               csr_radius = csr_data[idla_pkg::RADIUS_BITS-1:0];
               csr_known  = 1'b1;
            end
            idla_pkg::CSR_PARTICLES: begin
               pps_in    = csr_data[idla_pkg::PARTICLE_BITS-1:0];
               csr_known = 1'b1;
            end
            default: csr_known = 1'b0;
         endcase
         if (csr_known && (count_ff == '0)) begin
            source_in   = '0;
            released_in = '0;
            walk_x_in   = '0;
            walk_y_in   = COORD_BITS'(0) - COORD_BITS'(csr_radius);
            walk_z_in   = COORD_BITS'(0) - COORD_BITS'(csr_radius);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= idla_pkg::ST_IDLE;
         radius_ff    <= idla_pkg::RADIUS_RESET;
         pps_ff       <= idla_pkg::PARTICLES_RESET;
         count_ff     <= '0;
         walk_x_ff    <= '0;
         walk_y_ff    <= COORD_BITS'(0) - COORD_BITS'(idla_pkg::RADIUS_RESET);
         walk_z_ff    <= COORD_BITS'(0) - COORD_BITS'(idla_pkg::RADIUS_RESET);
         source_ff    <= '0;
         released_ff  <= '0;
         done_ff      <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         cmp_last_ff  <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         radius_ff    <= radius_in;
         pps_ff       <= pps_in;
         count_ff     <= count_in;
         walk_x_ff    <= walk_x_in;
         walk_y_ff    <= walk_y_in;
         walk_z_ff    <= walk_z_in;
         source_ff    <= source_in;
         released_ff  <= released_in;
         done_ff      <= done_in;
         cmp_vld_ff   <= cmp_vld_in;
         cmp_last_ff  <= cmp_last_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_addr_ff <= scan_addr_in;
      dir_ff       <= dir_in;
      div_q_ff     <= div_q_in;
      div_rem_ff   <= div_rem_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_z_ff     <= rsp_z_in;
      rsp_num_ff   <= rsp_num_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign req_chan.ready       = (state_ff == idla_pkg::ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.site_x      = rsp_x_ff;
   assign rsp_chan.site_y      = rsp_y_ff;
   assign rsp_chan.site_z      = rsp_z_ff;
   assign rsp_chan.site_number = rsp_num_ff;
   assign rsp_chan.run_last    = rsp_last_ff;
   assign rsp_chan.store_full  = rsp_full_ff;

endmodule

FILE: hw/rtl/idla_checker.sv
// Port-level assertion checker for the aggregation block and its bind statement.
module idla_checker (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   input  logic                                     req_ready,
   input  logic [idla_pkg::OPCODE_BITS-1:0]         req_opcode,
   input  logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   input  logic signed [idla_pkg::SITE_COORD_BITS-1:0] rsp_site_x,
   input  logic [idla_pkg::SITE_NUM_BITS-1:0]       rsp_site_number,
   input  logic                                     rsp_run_last,
   input  logic                                     rsp_store_full
);

   // A waiting response item holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_site_x)
                                  && $stable(rsp_site_number))
      else $error("response item changed while stalled");

   // A restart completes in the cycle it is accepted.
   a_restart_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_opcode == idla_pkg::OP_RESTART) |=> req_ready)
      else $error("block busy after a restart item");

   // A full store always ends the run.
   a_full_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_full |-> rsp_run_last)
      else $error("store full reported on a particle that does not end the run");

   // A new particle is only produced while the block is busy with a step.
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response item appeared without a step in progress");

endmodule

bind idla_multi_source_3d idla_checker u_idla_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_opcode      (req_chan.opcode),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_site_x      (rsp_chan.site_x),
   .rsp_site_number (rsp_chan.site_number),
   .rsp_run_last    (rsp_chan.run_last),
   .rsp_store_full  (rsp_chan.store_full)
);

FILE: tb/idla_site_checker.sv
// Checker that predicts the settled sites of the aggregation block and compares every result item.
module idla_site_checker #(
   parameter int MAX_SITES  = 4096,
   parameter int COORD_BITS = 14
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [idla_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [idla_pkg::CSR_DATA_BITS-1:0]  csr_data,
   idla_req_if                                 req_chan,
   idla_rsp_if                                 rsp_chan,
   output int                                  mismatch_count,
   output int                                  pending_count,
   output int                                  sites_checked,
   output int                                  runs_closed,
   output logic                                run_over
);
   import idla_pkg::*;

   typedef struct {
      coord_out_type            x;
      coord_out_type            y;
      coord_out_type            z;
      logic [SITE_NUM_BITS-1:0] number;
      logic                     last;
      logic                     full;
   } site_result_type;

   logic [COORD_BITS-1:0]    stored_x [MAX_SITES];
   logic [COORD_BITS-1:0]    stored_y [MAX_SITES];
   logic [COORD_BITS-1:0]    stored_z [MAX_SITES];
   int                       site_count;
   logic [COORD_BITS-1:0]    walk_x;
   logic [COORD_BITS-1:0]    walk_y;
   logic [COORD_BITS-1:0]    walk_z;
   logic [SOURCE_BITS-1:0]   source_idx;
   logic [PARTICLE_BITS-1:0] released;
   logic                     run_done;
   logic [RADIUS_BITS-1:0]   radius;
   logic [PARTICLE_BITS-1:0] particles;
   site_result_type          expected_sites [$];

   function automatic coord_out_type widen_coord(input logic [COORD_BITS-1:0] c);
      return coord_out_type'($signed(c));
   endfunction

   function automatic void place_walker();
      int side;
      int row;
      int col;
      side = 2 * int'(radius) + 1;
      row = int'(source_idx) / side - int'(radius);
      col = int'(source_idx) % side - int'(radius);
      walk_x = '0;
      walk_y = COORD_BITS'(row);
      walk_z = COORD_BITS'(col);
   endfunction

   function automatic void restart_run();
      site_count = 0;
      source_idx = '0;
      released = '0;
      run_done = 1'b0;
      place_walker();
   endfunction

   task automatic report_mismatch(input string what, input site_result_type want);
      $display("MISMATCH %s: got (%0d,%0d,%0d) n=%0d last=%0b full=%0b, %s (%0d,%0d,%0d) n=%0d %s",
               what, rsp_chan.site_x, rsp_chan.site_y, rsp_chan.site_z, rsp_chan.site_number,
               rsp_chan.run_last, rsp_chan.store_full, "expected", want.x, want.y, want.z,
               want.number, $sformatf("last=%0b full=%0b", want.last, want.full));
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      site_result_type want;
      site_result_type fresh;
      dir_type         dir;
      bit              hit;
      int              side;
      int              sources;
      if (reset) begin
         radius = RADIUS_RESET;
         particles = PARTICLES_RESET;
         restart_run();
         expected_sites.delete();
         mismatch_count = 0;
         sites_checked = 0;
         runs_closed = 0;
      end else begin
         if (csr_write_en === 1'b1 &&
             (csr_index == CSR_SOURCE_RADIUS || csr_index == CSR_PARTICLES)) begin
            if (csr_index == CSR_SOURCE_RADIUS)
               radius = RADIUS_BITS'(csr_data);
            else
               particles = PARTICLE_BITS'(csr_data);
            if (site_count == 0) begin
               source_idx = '0;
               released = '0;
               place_walker();
            end
         end

         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (expected_sites.size() == 0) begin
               want = '{default: '0};
               report_mismatch("result item with no settled site due", want);
            end else begin
               want = expected_sites.pop_front();
               if (rsp_chan.site_x !== want.x || rsp_chan.site_y !== want.y ||
                   rsp_chan.site_z !== want.z || rsp_chan.site_number !== want.number ||
                   rsp_chan.run_last !== want.last || rsp_chan.store_full !== want.full)
                  report_mismatch("settled site differs", want);
               sites_checked++;
               if (want.last)
                  runs_closed++;
            end
         end

         if (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) begin
            if (req_chan.opcode == OP_RESTART) begin
               restart_run();
            end else if (!run_done) begin
               hit = 1'b0;
               for (int i = 0; i < site_count && i < MAX_SITES; i++) begin
                  if (stored_x[i] == walk_x && stored_y[i] == walk_y && stored_z[i] == walk_z)
                     hit = 1'b1;
               end
               if (hit) begin
                  dir = dir_type'(3'((int'(req_chan.random_value) * 6) >> 16));
                  case (dir)
                     DIR_XP: walk_x = walk_x + 1'b1;
                     DIR_XN: walk_x = walk_x - 1'b1;
                     DIR_YP: walk_y = walk_y + 1'b1;
                     DIR_YN: walk_y = walk_y - 1'b1;
                     DIR_ZP: walk_z = walk_z + 1'b1;
                     DIR_ZN: walk_z = walk_z - 1'b1;
                     default: ;
                  endcase
               end else begin
                  stored_x[site_count % MAX_SITES] = walk_x;
                  stored_y[site_count % MAX_SITES] = walk_y;
                  stored_z[site_count % MAX_SITES] = walk_z;
                  fresh.x = widen_coord(walk_x);
                  fresh.y = widen_coord(walk_y);
                  fresh.z = widen_coord(walk_z);
                  fresh.number = SITE_NUM_BITS'(site_count);
                  fresh.last = 1'b0;
                  fresh.full = 1'b0;
                  site_count++;
                  released = released + 1'b1;
                  if (released >= particles || released == '0) begin
                     released = '0;
                     source_idx = source_idx + 1'b1;
                     side = 2 * int'(radius) + 1;
                     sources = side * side;
                     if (int'(source_idx) >= sources || source_idx == '0)
                        fresh.last = 1'b1;
                  end
                  if (site_count >= MAX_SITES) begin
                     fresh.last = 1'b1;
                     fresh.full = 1'b1;
                  end
                  if (fresh.last)
                     run_done = 1'b1;
                  else
                     place_walker();
                  expected_sites.insert(expected_sites.size(), fresh);
               end
            end
         end
      end
      pending_count = expected_sites.size();
      run_over <= run_done;
   end

endmodule

FILE: tb/testbench.sv
// Top of the aggregation block testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
   import idla_pkg::*;

   localparam int MAX_SITES       = 4096;
   localparam int COORD_BITS      = 14;
   localparam int DRAIN_TAIL      = MAX_SITES + 32;
   localparam int WATCHDOG_LIMIT  = 40000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int RANDOM_STEPS    = 100;
   localparam int PHASES          = 5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_HI = 2'd3;

   // The walk starts on the origin; values taken on an occupied site pick a move.
   localparam logic [RANDOM_BITS-1:0] MOVE_VALUES [17] = '{
      16'd0, 16'd10922, 16'd0, 16'd10923, 16'd0, 16'd21846, 16'd0, 16'd32768, 16'd0,
      16'd43691, 16'd0, 16'd65535, 16'd0, 16'd21845, 16'd32767, 16'd43690, 16'd54613
   };

   logic                      clock;
   logic                      reset;
   logic                      csr_write_en;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   logic                      steady;
   int                        hold_requests;
   int                        mismatch_count;
   int                        pending_count;
   int                        sites_checked;
   int                        runs_closed;
   logic                      run_over;
   int                        items_sent;
   int                        restarts_sent;
   int                        settings_used;

   idla_req_if req_if ();
   idla_rsp_if rsp_if ();

   idla_multi_source_3d #(
      .MAX_SITES(MAX_SITES),
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   idla_site_checker #(
      .MAX_SITES(MAX_SITES),
      .COORD_BITS(COORD_BITS)
   ) site_check (
      .clock(clock),
      .reset(reset),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .req_chan(req_if),
      .rsp_chan(rsp_if),
      .mismatch_count(mismatch_count),
      .pending_count(pending_count),
      .sites_checked(sites_checked),
      .runs_closed(runs_closed),
      .run_over(run_over)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic send_item(input logic [OPCODE_BITS-1:0] op, input logic [RANDOM_BITS-1:0] rv);
      if (!steady && $urandom_range(99) < 10) begin
         req_if.valid <= 1'b0;
         req_if.opcode <= OPCODE_BITS'($urandom);
         req_if.random_value <= RANDOM_BITS'($urandom);
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.opcode <= op;
      req_if.random_value <= rv;
      do
         @(posedge clock);
      while (req_if.ready !== 1'b1);
      items_sent++;
      if (op == OP_RESTART)
         restarts_sent++;
   endtask

   task automatic wait_for_results();
      req_if.valid <= 1'b0;
      do
         @(negedge clock);
      while (pending_count != 0);
   endtask

   task automatic settle_block();
      wait_for_results();
      repeat (DRAIN_TAIL) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
   endtask

   task automatic set_grid(input logic [RADIUS_BITS-1:0] r, input logic [PARTICLE_BITS-1:0] p);
      write_reg(CSR_SOURCE_RADIUS, CSR_DATA_BITS'(r));
      write_reg(CSR_PARTICLES, CSR_DATA_BITS'(p));
      csr_write_en <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int hold_left;
      int holds_done;
      hold_left = 0;
      holds_done = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left == 0 && holds_done != hold_requests) begin
            hold_left = RSP_HOLD_CYCLES;
            holds_done++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (steady) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= 10);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            quiet = 0;
         else
            quiet++;
      end
      $display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int phase;
      int useful;
      bit paused;
      items_sent = 0;
      restarts_sent = 0;
      settings_used = 0;
      paused = 1'b0;
      reset <= 1'b1;
      csr_write_en <= 1'b0;
      csr_index <= CSR_SOURCE_RADIUS;
      csr_data <= '0;
      req_if.valid <= 1'b0;
      req_if.opcode <= OP_STEP;
      req_if.random_value <= '0;
      steady <= 1'b0;
      hold_requests <= 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Single source at the origin, so that every move direction is taken.
      write_reg(CSR_SOURCE_RADIUS, '0);
      write_reg(CSR_PARTICLES, '1);
      write_reg(CSR_UNUSED_LO, '1);
      write_reg(CSR_UNUSED_HI, '0);
      csr_write_en <= 1'b0;
      settings_used++;
      foreach (MOVE_VALUES[i])
         send_item(OP_STEP, MOVE_VALUES[i]);

      // Widest grid with a zero particle count, then a shrink that ends the run.
      settle_block();
      write_reg(CSR_PARTICLES, '0);
      write_reg(CSR_SOURCE_RADIUS, CSR_DATA_BITS'(7));
      csr_write_en <= 1'b0;
      settings_used++;
      send_item(OP_RESTART, '1);
      repeat (3) send_item(OP_STEP, RANDOM_BITS'($urandom));
      settle_block();
      write_reg(CSR_SOURCE_RADIUS, '0);
      csr_write_en <= 1'b0;
      settings_used++;
      send_item(OP_STEP, '1);
      send_item(OP_STEP, '0);

      for (phase = 0; phase < PHASES; phase++) begin
         settle_block();
         if (phase % 2 == 0) begin
            send_item(OP_RESTART, RANDOM_BITS'($urandom));
            settle_block();
         end
         case (phase)
            0: set_grid(3'd0, 6'd4);
            1: set_grid(3'd7, 6'd1);
            2: set_grid(3'd1, 6'd63);
            3: set_grid(3'd3, 6'd5);
            default: set_grid(RADIUS_BITS'($urandom_range(7)), PARTICLE_BITS'($urandom_range(63)));
         endcase
         if (phase == 1) begin
            steady <= 1'b1;
            hold_requests <= hold_requests + 1;
         end
         useful = 0;
         while (useful < RANDOM_STEPS / PHASES) begin
            if (phase == 1 && useful == 12)
               steady <= 1'b0;
            if (phase == 3 && useful == 10 && !paused) begin
               wait_for_results();
               paused = 1'b1;
            end
            if (run_over) begin
               if ($urandom_range(9) < 8)
                  send_item(OP_RESTART, RANDOM_BITS'($urandom));
               else
                  send_item(OP_STEP, RANDOM_BITS'($urandom));
            end else if ($urandom_range(99) < 3) begin
               send_item(OP_RESTART, RANDOM_BITS'($urandom));
            end else begin
               send_item(OP_STEP, RANDOM_BITS'($urandom));
               useful++;
            end
         end
      end

      settle_block();
      $display("Sent %0d items, %0d of them restarts, under %0d register settings.",
               items_sent, restarts_sent, settings_used);
      $display("Compared %0d settled sites; %0d runs reached their last particle.",
               sites_checked, runs_closed);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
